// ===== rtl/core/mtd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_pkg: shared types and codes of the MessagePack tag decoder
// Beat formats, result kinds, error codes, tag classes and decoder phases.
// ----------------------------------------------------------------------------
package mtd_pkg;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [3:0] K_NIL     = 4'd0;
    localparam logic [3:0] K_BOOL    = 4'd1;
    localparam logic [3:0] K_UINT    = 4'd2;
    localparam logic [3:0] K_INT     = 4'd3;
    localparam logic [3:0] K_FLOAT   = 4'd4;
    localparam logic [3:0] K_DOUBLE  = 4'd5;
    localparam logic [3:0] K_STR     = 4'd6;
    localparam logic [3:0] K_BIN     = 4'd7;
    localparam logic [3:0] K_ARRAY   = 4'd8;
    localparam logic [3:0] K_MAP     = 4'd9;
    localparam logic [3:0] K_EXT     = 4'd10;
    localparam logic [3:0] K_PAYLOAD = 4'd11;
    localparam logic [3:0] K_ERROR   = 4'd12;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_TRUNC   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_mtd_in;

    typedef struct packed {
        logic [3:0]        kind;
        logic [63:0]       value;
        logic signed [7:0] ext_kind;
        logic [1:0]        error_code;
        logic              last_payload;
    } t_mtd_out;

    typedef enum logic [1:0] {
        ACT_EMIT   = 2'd0,
        ACT_STR    = 2'd1,
        ACT_GATHER = 2'd2,
        ACT_EXTFIX = 2'd3
    } t_mtd_act;

    typedef struct packed {
        t_mtd_act   act;
        logic [3:0] kind;
        logic [7:0] imm;
        logic       sext;
        logic [1:0] err;
        logic [3:0] nbytes;
        logic [1:0] sw;
        logic       ext;
    } t_mtd_cls;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eos;
        t_mtd_cls   cls;
    } t_mtd_mid;

    typedef enum logic [3:0] {
        PH_TAG     = 4'b0001,
        PH_GATHER  = 4'b0010,
        PH_EXTTYPE = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } t_mtd_phase;

endpackage
`default_nettype wire

// ===== rtl/core/msgpack_tag_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msgpack_tag_decoder: MessagePack type tag decoder
// Decodes a MessagePack byte stream into header, value, payload and error beats.
//
//   Channel  Direction  Handshake        Beat
//   input    in         push / full      i_item (t_mtd_in)
//   result   out        pop / empty      o_item (t_mtd_out)
//
// One byte is taken per cycle while the input queue is not full; each byte gives at most one result beat.
// A result beat is formed as its byte leaves the middle queue, while the result queue
// is not full, and is registered in the result queue, from which it can then be popped.
// The classifier and the phase sequencer are parted by a small queue, so
// a stalled result side fills that queue before full is raised.
// Reset is synchronous and returns the decoder to expecting a tag.
// ----------------------------------------------------------------------------
module msgpack_tag_decoder
    import mtd_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire t_mtd_in i_item,
    input  wire logic    pop,
    output logic         empty,
    output t_mtd_out     o_item
);

    t_mtd_mid w_entry;
    t_mtd_mid w_mid;
    logic     w_mid_empty;
    logic     w_mid_pop;
    logic     w_out_full;
    logic     w_out_push;
    t_mtd_out w_out;

    mtd_front u_front (
        .i_item  (i_item),
        .o_entry (w_entry)
    );

    mtd_fifo #(
        .T     (t_mtd_mid),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_entry),
        .o_full  (full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid),
        .o_empty (w_mid_empty)
    );

    mtd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid       (w_mid),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .i_out_full  (w_out_full),
        .o_out_push  (w_out_push),
        .o_out       (w_out)
    );

    mtd_fifo #(
        .T     (t_mtd_out),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_item),
        .o_empty (empty)
    );

endmodule
`default_nettype wire

// ===== rtl/core/mtd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_fifo: small first-in first-out queue of beats
// Flop-based slots with a registered fill count; full and empty flags are decoded from it.
// ----------------------------------------------------------------------------
module mtd_fifo
    import mtd_pkg::*;
#(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire T     i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output T          o_data,
    output logic      o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                r_slot [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_count;
    logic            w_wen;
    logic            w_ren;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd];
    assign w_wen   = i_push && !o_full;
    assign w_ren   = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_wen) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_ren) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (w_wen && !w_ren) begin
            n_count = r_count + CW'(1);
        end else if (w_ren && !w_wen) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mtd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_front: tag classifier
// Decodes each incoming byte as a tag and attaches the class to the beat.
// ----------------------------------------------------------------------------
module mtd_front
    import mtd_pkg::*;
(
    input  wire t_mtd_in i_item,
    output t_mtd_mid     o_entry
);

    logic [7:0] w_b;
    logic [2:0] w_fix_sh;
    t_mtd_cls   w_cls;

    function automatic t_mtd_cls f_gather(
        input logic [3:0] kind,
        input logic [3:0] nbytes,
        input logic [1:0] sw,
        input logic       ext
    );
        t_mtd_cls c;
        c        = '0;
        c.act    = ACT_GATHER;
        c.kind   = kind;
        c.nbytes = nbytes;
        c.sw     = sw;
        c.ext    = ext;
        c.err    = ERR_NONE;
        return c;
    endfunction

    assign w_b      = i_item.data_byte;
    assign w_fix_sh = 3'(w_b - 8'hd4);

    always_comb begin
        w_cls      = '0;
        w_cls.act  = ACT_EMIT;
        w_cls.kind = K_ERROR;
        w_cls.err  = ERR_INVALID;
        unique case (w_b) inside
            [8'h00:8'h7f]: begin
                w_cls.kind = K_UINT;
                w_cls.imm  = w_b;
                w_cls.err  = ERR_NONE;
            end
            [8'he0:8'hff]: begin
                w_cls.kind = K_INT;
                w_cls.imm  = w_b;
                w_cls.sext = 1'b1;
                w_cls.err  = ERR_NONE;
            end
            [8'h80:8'h8f]: begin
                w_cls.kind = K_MAP;
                w_cls.imm  = {4'b0, w_b[3:0]};
                w_cls.err  = ERR_NONE;
            end
            [8'h90:8'h9f]: begin
                w_cls.kind = K_ARRAY;
                w_cls.imm  = {4'b0, w_b[3:0]};
                w_cls.err  = ERR_NONE;
            end
            [8'ha0:8'hbf]: begin
                w_cls.act  = ACT_STR;
                w_cls.kind = K_STR;
                w_cls.imm  = {3'b0, w_b[4:0]};
                w_cls.err  = ERR_NONE;
            end
            8'hc0: begin
                w_cls.kind = K_NIL;
                w_cls.err  = ERR_NONE;
            end
            8'hc2, 8'hc3: begin
                w_cls.kind = K_BOOL;
                w_cls.imm  = {7'b0, w_b[0]};
                w_cls.err  = ERR_NONE;
            end
            8'hc4: w_cls = f_gather(K_BIN, 4'd1, 2'd0, 1'b0);
            8'hc5: w_cls = f_gather(K_BIN, 4'd2, 2'd0, 1'b0);
            8'hc6: w_cls = f_gather(K_BIN, 4'd4, 2'd0, 1'b0);
            8'hc7: w_cls = f_gather(K_EXT, 4'd1, 2'd0, 1'b1);
            8'hc8: w_cls = f_gather(K_EXT, 4'd2, 2'd0, 1'b1);
            8'hc9: w_cls = f_gather(K_EXT, 4'd4, 2'd0, 1'b1);
            8'hca: w_cls = f_gather(K_FLOAT, 4'd4, 2'd0, 1'b0);
            8'hcb: w_cls = f_gather(K_DOUBLE, 4'd8, 2'd0, 1'b0);
            8'hcc: w_cls = f_gather(K_UINT, 4'd1, 2'd0, 1'b0);
            8'hcd: w_cls = f_gather(K_UINT, 4'd2, 2'd0, 1'b0);
            8'hce: w_cls = f_gather(K_UINT, 4'd4, 2'd0, 1'b0);
            8'hcf: w_cls = f_gather(K_UINT, 4'd8, 2'd0, 1'b0);
            8'hd0: w_cls = f_gather(K_INT, 4'd1, 2'd0, 1'b0);
            8'hd1: w_cls = f_gather(K_INT, 4'd2, 2'd1, 1'b0);
            8'hd2: w_cls = f_gather(K_INT, 4'd4, 2'd2, 1'b0);
            8'hd3: w_cls = f_gather(K_INT, 4'd8, 2'd3, 1'b0);
            [8'hd4:8'hd8]: begin
                w_cls.act  = ACT_EXTFIX;
                w_cls.kind = K_EXT;
                w_cls.imm  = 8'h01 << w_fix_sh;
                w_cls.err  = ERR_NONE;
            end
            8'hd9: w_cls = f_gather(K_STR, 4'd1, 2'd0, 1'b0);
            8'hda: w_cls = f_gather(K_STR, 4'd2, 2'd0, 1'b0);
            8'hdb: w_cls = f_gather(K_STR, 4'd4, 2'd0, 1'b0);
            8'hdc: w_cls = f_gather(K_ARRAY, 4'd2, 2'd0, 1'b0);
            8'hdd: w_cls = f_gather(K_ARRAY, 4'd4, 2'd0, 1'b0);
            8'hde: w_cls = f_gather(K_MAP, 4'd2, 2'd0, 1'b0);
            8'hdf: w_cls = f_gather(K_MAP, 4'd4, 2'd0, 1'b0);
            default: begin
                w_cls.kind = K_ERROR;
                w_cls.err  = ERR_INVALID;
            end
        endcase
    end

    assign o_entry.data_byte = w_b;
    assign o_entry.eos       = i_item.end_of_stream;
    assign o_entry.cls       = w_cls;

endmodule
`default_nettype wire

// ===== rtl/core/mtd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtd_back: header gatherer and payload sequencer
// Runs the decoder phases on classified beats and forms the result beats.
// ----------------------------------------------------------------------------
module mtd_back
    import mtd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mtd_mid i_mid,
    input  wire logic     i_mid_empty,
    output logic          o_mid_pop,
    input  wire logic     i_out_full,
    output logic          o_out_push,
    output t_mtd_out      o_out
);

    t_mtd_phase  r_phase;
    logic [3:0]  r_pending;
    logic [3:0]  r_bytes_left;
    logic [63:0] r_acc;
    logic [1:0]  r_sw;
    logic        r_ext;
    logic [31:0] r_payload_left;

    t_mtd_phase  n_phase;
    logic [3:0]  n_pending;
    logic [3:0]  n_bytes_left;
    logic [63:0] n_acc;
    logic [1:0]  n_sw;
    logic        n_ext;
    logic [31:0] n_payload_left;

    logic        w_go;
    logic [7:0]  w_b;
    logic [63:0] w_acc_sh;
    logic [3:0]  w_bl_dec;
    logic [63:0] w_val;
    logic [31:0] w_pl_dec;
    t_mtd_cls    w_cls;

    function automatic logic [63:0] f_sext(input logic [63:0] v, input logic [1:0] sw);
        logic [63:0] r;
        case (sw)
            2'd0:    r = {{56{v[7]}}, v[7:0]};
            2'd1:    r = {{48{v[15]}}, v[15:0]};
            2'd2:    r = {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    assign w_go      = !i_mid_empty && !i_out_full;
    assign o_mid_pop = w_go;
    assign w_b       = i_mid.data_byte;
    assign w_cls     = i_mid.cls;
    assign w_acc_sh  = {r_acc[55:0], w_b};
    assign w_bl_dec  = r_bytes_left - 4'd1;
    assign w_pl_dec  = r_payload_left - 32'd1;
    assign w_val     = (r_pending == K_INT) ? f_sext(w_acc_sh, r_sw) : w_acc_sh;

    always_comb begin
        n_phase        = r_phase;
        n_pending      = r_pending;
        n_bytes_left   = r_bytes_left;
        n_acc          = r_acc;
        n_sw           = r_sw;
        n_ext          = r_ext;
        n_payload_left = r_payload_left;
        o_out_push     = 1'b0;
        o_out          = '0;
        if (w_go) begin
            if (i_mid.eos) begin
                if (r_phase != PH_TAG) begin
                    n_phase          = PH_TAG;
                    n_pending        = '0;
                    n_bytes_left     = '0;
                    n_acc            = '0;
                    n_sw             = '0;
                    n_ext            = 1'b0;
                    n_payload_left   = '0;
                    o_out_push       = 1'b1;
                    o_out.kind       = K_ERROR;
                    o_out.error_code = ERR_TRUNC;
                end
            end else begin
                unique case (r_phase)
                    PH_TAG: begin
                        unique case (w_cls.act)
                            ACT_EMIT: begin
                                o_out_push       = 1'b1;
                                o_out.kind       = w_cls.kind;
                                o_out.value      = w_cls.sext ?
                                    {{56{w_cls.imm[7]}}, w_cls.imm} : {56'b0, w_cls.imm};
                                o_out.error_code = w_cls.err;
                            end
                            ACT_STR: begin
                                o_out_push     = 1'b1;
                                o_out.kind     = K_STR;
                                o_out.value    = {56'b0, w_cls.imm};
                                n_payload_left = {24'b0, w_cls.imm};
                                n_phase        = (w_cls.imm != '0) ? PH_PAYLOAD : PH_TAG;
                            end
                            ACT_GATHER: begin
                                n_phase      = PH_GATHER;
                                n_pending    = w_cls.kind;
                                n_bytes_left = w_cls.nbytes;
                                n_acc        = '0;
                                n_sw         = w_cls.sw;
                                n_ext        = w_cls.ext;
                            end
                            default: begin
                                n_phase        = PH_EXTTYPE;
                                n_pending      = K_EXT;
                                n_bytes_left   = '0;
                                n_acc          = {56'b0, w_cls.imm};
                                n_sw           = '0;
                                n_ext          = 1'b0;
                                n_payload_left = '0;
                            end
                        endcase
                    end
                    PH_GATHER: begin
                        n_acc        = w_acc_sh;
                        n_bytes_left = w_bl_dec;
                        if (w_bl_dec == '0) begin
                            if (r_ext) begin
                                n_phase = PH_EXTTYPE;
                                n_ext   = 1'b0;
                            end else begin
                                o_out_push     = 1'b1;
                                o_out.kind     = r_pending;
                                o_out.value    = w_val;
                                n_pending      = '0;
                                n_acc          = '0;
                                n_sw           = '0;
                                n_payload_left = '0;
                                n_phase        = PH_TAG;
                                if ((r_pending == K_STR) || (r_pending == K_BIN)) begin
                                    n_payload_left = w_val[31:0];
                                    if (w_val[31:0] != '0) begin
                                        n_phase = PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                    end
                    PH_EXTTYPE: begin
                        o_out_push     = 1'b1;
                        o_out.kind     = K_EXT;
                        o_out.value    = r_acc;
                        o_out.ext_kind = $signed(w_b);
                        n_pending      = '0;
                        n_bytes_left   = '0;
                        n_acc          = '0;
                        n_sw           = '0;
                        n_ext          = 1'b0;
                        n_payload_left = r_acc[31:0];
                        n_phase        = (r_acc[31:0] != '0) ? PH_PAYLOAD : PH_TAG;
                    end
                    default: begin
                        o_out_push         = 1'b1;
                        o_out.kind         = K_PAYLOAD;
                        o_out.value        = {56'b0, w_b};
                        o_out.last_payload = (r_payload_left == 32'd1);
                        n_payload_left     = w_pl_dec;
                        if (w_pl_dec == '0) begin
                            n_phase   = PH_TAG;
                            n_pending = '0;
                            n_acc     = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_TAG;
            r_pending      <= '0;
            r_bytes_left   <= '0;
            r_acc          <= '0;
            r_sw           <= '0;
            r_ext          <= 1'b0;
            r_payload_left <= '0;
        end else begin
            r_phase        <= n_phase;
            r_pending      <= n_pending;
            r_bytes_left   <= n_bytes_left;
            r_acc          <= n_acc;
            r_sw           <= n_sw;
            r_ext          <= n_ext;
            r_payload_left <= n_payload_left;
        end
    end

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_payload_left != '0))
        else $error("payload phase with no payload bytes left");

    a_gather_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_GATHER) |-> (r_bytes_left != '0))
        else $error("gather phase with no header bytes left");

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("decoder phase is not one-hot");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> o_mid_pop)
        else $error("result beat formed without a consumed input beat");

endmodule
`default_nettype wire
